>>> hw/rtl/stkrot_pkg.sv
// Package for the stack engine with rotate.
// Holds request and status codes, state encoding and payload types.
// No dependencies.
`default_nettype none

package stkrot_pkg;

	localparam int WORD_W    = 32;
	localparam int AMT_W     = 16;
	localparam int CNT_OUT_W = 7;
	localparam int STEP_W    = $clog2(AMT_W);
	localparam int PADDR_W   = 3;

	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [AMT_W-1:0]     amt_t;
	typedef logic [CNT_OUT_W-1:0] cnt_out_t;
	typedef logic [2:0]           req_type_t;

	localparam logic [0:0] REG_THRESHOLD   = 1'b0;
	localparam word_t      THRESHOLD_RESET = 32'd4;

	typedef enum logic [2:0] {
		REQ_PUSH      = 3'd0,
		REQ_POP       = 3'd1,
		REQ_REVERSE   = 3'd2,
		REQ_SWAP_TWO  = 3'd3,
		REQ_SWAP_ENDS = 3'd4,
		REQ_ROTATE    = 3'd5,
		REQ_QUERY     = 3'd6
	} req_code_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POP_WAIT,
		ST_DIV,
		ST_SEG_CHK,
		ST_SW_RD_A,
		ST_SW_RD_B,
		ST_SW_WR_A,
		ST_SW_WR_B,
		ST_POST,
		ST_RECOUNT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		word_t    popped_value;
		status_t  status;
		cnt_out_t depth_now;
		cnt_out_t above_count;
	} rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/stkrot_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on stkrot_pkg.
`default_nettype none

interface stkrot_req_if
	import stkrot_pkg::*;
	();
	logic      valid;
	logic      ready;
	req_type_t req_type;
	word_t     push_value;
	amt_t      rotate_amount;

	modport source (output valid, output req_type, output push_value,
		output rotate_amount, input ready);
	modport sink (input valid, input req_type, input push_value,
		input rotate_amount, output ready);
endinterface

interface stkrot_rsp_if
	import stkrot_pkg::*;
	();
	logic     valid;
	logic     ready;
	word_t    popped_value;
	status_t  status;
	cnt_out_t depth_now;
	cnt_out_t above_count;

	modport source (output valid, output popped_value, output status,
		output depth_now, output above_count, input ready);
	modport sink (input valid, input popped_value, input status,
		input depth_now, input above_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/stkrot_mem.sv
// Entry storage: one write port, one read port, registered read data.
// Depends on stkrot_pkg.
`default_nettype none

module stkrot_mem
	import stkrot_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire word_t         wdata,
	input  wire logic [AW-1:0] raddr,
	output word_t              rdata
);

	word_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/stkrot_div.sv
// Restoring remainder unit: rotate amount modulo stack length, one bit a cycle.
// Depends on stkrot_pkg.
`default_nettype none

module stkrot_div
	import stkrot_pkg::*;
#(
	parameter int CW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire amt_t          dividend,
	input  wire logic [CW-1:0] divisor,
	output logic               done,
	output logic [CW-1:0]      rem
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	amt_t              dvd_q;
	logic [CW-1:0]     rem_q;
	logic [CW-1:0]     dsr_q;
	logic [CW:0]       trial;
	logic [CW:0]       diff;

	assign trial = {rem_q, dvd_q[AMT_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign done  = done_q;
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == STEP_W'(AMT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			step_q <= '0;
			dvd_q  <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			dvd_q  <= {dvd_q[AMT_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff[CW-1:0];
			end else begin
				rem_q <= trial[CW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/stkrot_ctrl.sv
// Sequencer: decodes each request, reads, modifies and writes back the entry
// storage, keeps pointer, length, direction and the above-threshold tally.
// Depends on stkrot_pkg and stkrot_if.
`default_nettype none

module stkrot_ctrl
	import stkrot_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int CW    = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	stkrot_req_if.sink         req,
	input  wire word_t         threshold,
	input  wire logic          threshold_wr,
	output logic               res_valid,
	input  wire logic          res_ready,
	output rsp_t               res,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output word_t              mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  wire word_t         mem_rdata,
	output logic               div_start,
	output amt_t               div_dividend,
	output logic [CW-1:0]      div_divisor,
	input  wire logic          div_done,
	input  wire logic [CW-1:0] div_rem
);

	localparam logic [AW:0]   DEPTH_SLOT = (AW+1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_CNT  = CW'(DEPTH);

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
		input logic rev, input logic [AW-1:0] pos);
		logic [AW:0] sum;
		if (rev) begin
			if (base >= pos) begin
				sum = {1'b0, base} - {1'b0, pos};
			end else begin
				sum = {1'b0, base} + DEPTH_SLOT - {1'b0, pos};
			end
		end else begin
			sum = {1'b0, base} + {1'b0, pos};
			if (sum >= DEPTH_SLOT) begin
				sum = sum - DEPTH_SLOT;
			end
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic above(input word_t w, input word_t t);
		return $signed(w) > $signed(t);
	endfunction

	state_t        state_q, state_d;
	logic [AW-1:0] base_q, base_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          rev_q, rev_d;
	logic [CW-1:0] tally_q, tally_d;
	logic          dirty_q, dirty_d;

	req_type_t     req_q, req_d;
	word_t         val_q, val_d;
	amt_t          amt_q, amt_d;
	word_t         popped_q, popped_d;
	status_t       status_q, status_d;
	logic [AW-1:0] lo_q, lo_d;
	logic [AW-1:0] hi_q, hi_d;
	logic          phase_q, phase_d;
	logic          rot_q, rot_d;
	logic [CW-1:0] rot_r_q, rot_r_d;
	logic [AW-1:0] sw_a_q, sw_a_d;
	logic [AW-1:0] sw_b_q, sw_b_d;
	word_t         tmp_q, tmp_d;
	logic [CW-1:0] pos_q, pos_d;
	logic          pend_s1, pend_d;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [CW-1:0] seg_a_hi;
	logic [CW-1:0] seg_b_lo;
	logic [AW-1:0] top_slot;

	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_m2   = cnt_q - CW'(2);
	assign seg_a_hi = cnt_q - div_rem - CW'(1);
	assign seg_b_lo = cnt_q - rot_r_q;
	assign top_slot = slot_of(base_q, rev_q, cnt_m1[AW-1:0]);

	assign div_dividend = amt_q;
	assign div_divisor  = cnt_q;

	assign res.popped_value = popped_q;
	assign res.status       = status_q;
	assign res.depth_now    = cnt_out_t'(cnt_q);
	assign res.above_count  = cnt_out_t'(tally_q);

	always_comb begin
		state_d   = state_q;
		base_d    = base_q;
		cnt_d     = cnt_q;
		rev_d     = rev_q;
		tally_d   = tally_q;
		dirty_d   = dirty_q;
		req_d     = req_q;
		val_d     = val_q;
		amt_d     = amt_q;
		popped_d  = popped_q;
		status_d  = status_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		phase_d   = phase_q;
		rot_d     = rot_q;
		rot_r_d   = rot_r_q;
		sw_a_d    = sw_a_q;
		sw_b_d    = sw_b_q;
		tmp_d     = tmp_q;
		pos_d     = pos_q;
		pend_d    = pend_s1;
		req.ready = (state_q == ST_IDLE);
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = sw_a_q;
		mem_wdata = tmp_q;
		mem_raddr = sw_a_q;
		div_start = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					req_d    = req.req_type;
					val_d    = req.push_value;
					amt_d    = req.rotate_amount;
					popped_d = '0;
					status_d = STAT_OK;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_POST;
				case (req_q)
					REQ_PUSH: begin
						if (cnt_q == DEPTH_CNT) begin
							status_d = STAT_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = slot_of(base_q, rev_q, cnt_q[AW-1:0]);
							mem_wdata = val_q;
							cnt_d     = cnt_q + CW'(1);
							tally_d   = tally_q + CW'(above(val_q, threshold));
						end
					end
					REQ_POP: begin
						if (cnt_q == '0) begin
							status_d = STAT_EMPTY;
						end else begin
							mem_raddr = top_slot;
							state_d   = ST_POP_WAIT;
						end
					end
					REQ_REVERSE: begin
						if (cnt_q != '0) begin
							base_d = top_slot;
							rev_d  = ~rev_q;
						end
					end
					REQ_SWAP_TWO: begin
						if (cnt_q > CW'(1)) begin
							sw_a_d  = top_slot;
							sw_b_d  = slot_of(base_q, rev_q, cnt_m2[AW-1:0]);
							rot_d   = 1'b0;
							state_d = ST_SW_RD_A;
						end
					end
					REQ_SWAP_ENDS: begin
						if (cnt_q > CW'(1)) begin
							sw_a_d  = top_slot;
							sw_b_d  = base_q;
							rot_d   = 1'b0;
							state_d = ST_SW_RD_A;
						end
					end
					REQ_ROTATE: begin
						if (cnt_q > CW'(1)) begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
					end
					default: begin
						state_d = ST_POST;
					end
				endcase
			end
			ST_POP_WAIT: begin
				popped_d = mem_rdata;
				cnt_d    = cnt_m1;
				tally_d  = tally_q - CW'(above(mem_rdata, threshold));
				state_d  = ST_POST;
			end
			ST_DIV: begin
				if (div_done) begin
					if (div_rem == '0) begin
						state_d = ST_POST;
					end else begin
						rot_r_d = div_rem;
						lo_d    = '0;
						hi_d    = seg_a_hi[AW-1:0];
						phase_d = 1'b0;
						rot_d   = 1'b1;
						state_d = ST_SEG_CHK;
					end
				end
			end
			ST_SEG_CHK: begin
				if (lo_q < hi_q) begin
					sw_a_d  = slot_of(base_q, rev_q, lo_q);
					sw_b_d  = slot_of(base_q, rev_q, hi_q);
					state_d = ST_SW_RD_A;
				end else if (!phase_q) begin
					phase_d = 1'b1;
					lo_d    = seg_b_lo[AW-1:0];
					hi_d    = cnt_m1[AW-1:0];
				end else begin
					base_d  = top_slot;
					rev_d   = ~rev_q;
					state_d = ST_POST;
				end
			end
			ST_SW_RD_A: begin
				mem_raddr = sw_a_q;
				state_d   = ST_SW_RD_B;
			end
			ST_SW_RD_B: begin
				mem_raddr = sw_b_q;
				tmp_d     = mem_rdata;
				state_d   = ST_SW_WR_A;
			end
			ST_SW_WR_A: begin
				mem_we    = 1'b1;
				mem_waddr = sw_a_q;
				mem_wdata = mem_rdata;
				state_d   = ST_SW_WR_B;
			end
			ST_SW_WR_B: begin
				mem_we    = 1'b1;
				mem_waddr = sw_b_q;
				mem_wdata = tmp_q;
				if (rot_q) begin
					lo_d    = lo_q + AW'(1);
					hi_d    = hi_q - AW'(1);
					state_d = ST_SEG_CHK;
				end else begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				if (dirty_q) begin
					tally_d = '0;
					pos_d   = '0;
					pend_d  = 1'b0;
					state_d = ST_RECOUNT;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_RECOUNT: begin
				if (pend_s1) begin
					tally_d = tally_q + CW'(above(mem_rdata, threshold));
				end
				if (pos_q != cnt_q) begin
					mem_raddr = slot_of(base_q, rev_q, pos_q[AW-1:0]);
					pos_d     = pos_q + CW'(1);
					pend_d    = 1'b1;
				end else begin
					pend_d = 1'b0;
					if (!pend_s1) begin
						dirty_d = 1'b0;
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (threshold_wr) begin
			dirty_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			base_q  <= '0;
			cnt_q   <= '0;
			rev_q   <= 1'b0;
			tally_q <= '0;
			dirty_q <= 1'b0;
		end else begin
			state_q <= state_d;
			base_q  <= base_d;
			cnt_q   <= cnt_d;
			rev_q   <= rev_d;
			tally_q <= tally_d;
			dirty_q <= dirty_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q    <= req_d;
		val_q    <= val_d;
		amt_q    <= amt_d;
		popped_q <= popped_d;
		status_q <= status_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		phase_q  <= phase_d;
		rot_q    <= rot_d;
		rot_r_q  <= rot_r_d;
		sw_a_q   <= sw_a_d;
		sw_b_q   <= sw_b_d;
		tmp_q    <= tmp_d;
		pos_q    <= pos_d;
		pend_s1  <= pend_d;
	end

endmodule

`default_nettype wire

>>> hw/rtl/stack_engine_with_rotate.sv
// Bounded LIFO stack of signed 32-bit words with reverse, swap and rotate.
// One item is worked on at a time; every request item gives one result item.
// Each swap adds a read-modify-write pass (read A, read B, write A, write B)
// on the single-read, single-write entry memory. Rotate adds the bit-serial
// modulo of the amount by the length, then an exchange of entry pairs.
// The first item after a threshold write adds a recount pass over the
// memory. A result waits in an output register, so the next item is taken
// while it is held.
// Depends on stkrot_pkg, stkrot_if, stkrot_mem, stkrot_div and stkrot_ctrl.
`default_nettype none

module stack_engine_with_rotate
	import stkrot_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire word_t              pwdata,
	output word_t                   prdata,
	output logic                    pready,
	stkrot_req_if.sink              req,
	stkrot_rsp_if.source            rsp
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	word_t         threshold_q;
	logic          threshold_wr;
	logic          res_valid;
	logic          res_ready;
	rsp_t          res;
	logic          out_valid_q;
	rsp_t          out_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	word_t         mem_wdata;
	logic [AW-1:0] mem_raddr;
	word_t         mem_rdata;
	logic          div_start;
	amt_t          div_dividend;
	logic [CW-1:0] div_divisor;
	logic          div_done;
	logic [CW-1:0] div_rem;

	assign pready       = 1'b1;
	assign threshold_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1:2] == REG_THRESHOLD);
	assign prdata       = (paddr[PADDR_W-1:2] == REG_THRESHOLD) ? threshold_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (threshold_wr) begin
			threshold_q <= pwdata;
		end
	end

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = out_q.popped_value;
	assign rsp.status       = out_q.status;
	assign rsp.depth_now    = out_q.depth_now;
	assign rsp.above_count  = out_q.above_count;

	stkrot_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	stkrot_div #(
		.CW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.rem      (div_rem)
	);

	stkrot_ctrl #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.threshold    (threshold_q),
		.threshold_wr (threshold_wr),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_rem      (div_rem)
	);

endmodule

`default_nettype wire
